// ===== sv/hog_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Hilbert order grouper: payload structs, sequencer states
// and fixed constants. No dependencies.
package hog_pkg;

    localparam int KEY_W = 62;
    localparam int TAG_W = 16;
    localparam int CRD_W = 16;
    localparam int GSZ_W = 7;
    localparam int GRP_W = 6;
    localparam logic [GSZ_W-1:0] GSZ_RESET = 7'd16;
    localparam logic [1:0] ADDR_GSZ = 2'd0;

    typedef struct packed {
        logic [CRD_W-1:0] x_coord;
        logic [CRD_W-1:0] y_coord;
        logic [TAG_W-1:0] point_tag;
        logic             last_point;
    } t_in_beat;

    typedef struct packed {
        logic [TAG_W-1:0] out_tag;
        logic [KEY_W-1:0] hilbert_key;
        logic [GRP_W-1:0] group_number;
        logic             group_end;
        logic             set_end;
        logic             overflowed;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RANGE,
        S_RDPT,
        S_DIVX,
        S_DIVY,
        S_HILB,
        S_WRKEY,
        S_SORT_START,
        S_SORT_KEY,
        S_SORT_PROBE,
        S_SORT_ORD,
        S_SORT_CMP,
        S_OUT_ORD,
        S_OUT_MEM,
        S_OUT_SEND
    } t_state;

endpackage

// ===== sv/hilbert_order_grouper_core.sv =====
`timescale 1ns / 1ps
// Hilbert order grouper top level. Loading takes one cycle per point. After the
// last point the range is fixed, then each point goes through a read, two
// 47-step divides with their start and finish, GRID_BITS Hilbert steps and
// a key write. A stable insertion sort follows, with up to N*(N-1)/2 compare
// steps. Each output beat is then read out and held through any stall.
// Not ready meanwhile; the next set loads after the last beat.
// Synchronous active-low reset empties the set and sets group_size to 16.
module hilbert_order_grouper_core
    import hog_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int GRID_BITS  = 31
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in_beat        i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output t_out_beat       o_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [1:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NUM_W = CRD_W + GRID_BITS;
    localparam int LVL_W = $clog2(GRID_BITS + 1);

    t_state r_state, n_state;
    logic [GSZ_W-1:0] r_gsz;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CRD_W-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic [CRD_W-1:0] n_minx, n_maxx, n_miny, n_maxy;
    logic r_drop, n_drop;
    logic [CRD_W-1:0] r_range, n_range;

    logic [47:0]      r_pmem [MAX_POINTS];
    logic [KEY_W-1:0] r_kmem [MAX_POINTS];
    logic [IDX_W-1:0] r_omem [MAX_POINTS];
    logic [47:0]      r_prd;
    logic [KEY_W-1:0] r_krd;
    logic [IDX_W-1:0] r_ord;

    logic [CNT_W-1:0] r_i, n_i, r_j, n_j;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [KEY_W-1:0] r_curkey, n_curkey;
    logic [GRID_BITS-1:0] r_gx, n_gx, r_gy, n_gy;
    logic [KEY_W-1:0] r_key, n_key;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [GSZ_W-1:0] r_gpos, n_gpos;
    logic [GRP_W-1:0] r_gnum, n_gnum;

    // memory port controls
    logic pm_we, km_we, om_we;
    logic [IDX_W-1:0] pm_wa, pm_ra, km_wa, km_ra, om_wa, om_ra, om_wd;

    logic div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [GRID_BITS-1:0] div_q;
    logic [CRD_W-1:0] w_dx, w_dy, w_rx, w_ry;
    logic w_acc, w_store;
    logic [GSZ_W-1:0] w_gs;
    logic w_bx, w_by;
    logic [1:0] w_quad;
    logic w_final;
    logic [IDX_W-1:0] w_jm1;

    hog_divider #(.NUM_W(NUM_W), .DEN_W(CRD_W), .Q_W(GRID_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(r_range), .o_done(div_done), .o_quot(div_q)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GSZ) ? {{(32-GSZ_W){1'b0}}, r_gsz} : 32'd0;

    assign w_acc   = i_valid && o_ready;
    assign w_store = r_cnt < CNT_W'(MAX_POINTS);
    assign w_rx    = (r_maxx >= r_minx) ? r_maxx - r_minx : '0;
    assign w_ry    = (r_maxy >= r_miny) ? r_maxy - r_miny : '0;
    assign w_dx    = r_prd[15:0] - r_minx;
    assign w_dy    = r_prd[31:16] - r_miny;
    assign w_gs    = (r_gsz == '0) ? GSZ_W'(1) : r_gsz;
    assign w_bx    = r_gx[GRID_BITS-1];
    assign w_by    = r_gy[GRID_BITS-1];
    assign w_quad  = {w_bx, w_bx ^ w_by};
    assign w_final = (r_i + 1'b1) == r_cnt;
    assign w_jm1   = r_j[IDX_W-1:0] - 1'b1;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_drop = r_drop; n_range = r_range;
        n_minx = r_minx; n_maxx = r_maxx; n_miny = r_miny; n_maxy = r_maxy;
        n_i = r_i; n_j = r_j; n_cur = r_cur; n_curkey = r_curkey;
        n_gx = r_gx; n_gy = r_gy; n_key = r_key; n_lvl = r_lvl;
        n_gpos = r_gpos; n_gnum = r_gnum;
        pm_we = 1'b0; km_we = 1'b0; om_we = 1'b0;
        pm_wa = r_cnt[IDX_W-1:0]; pm_ra = r_i[IDX_W-1:0];
        km_wa = r_i[IDX_W-1:0]; km_ra = r_i[IDX_W-1:0];
        om_wa = r_j[IDX_W-1:0]; om_ra = r_i[IDX_W-1:0]; om_wd = r_cur;
        div_start = 1'b0; div_num = '0;
        o_ready = 1'b0; o_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (w_acc) begin
                    if (w_store) begin
                        pm_we = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        if (i_data.x_coord < r_minx) n_minx = i_data.x_coord;
                        if (i_data.x_coord > r_maxx) n_maxx = i_data.x_coord;
                        if (i_data.y_coord < r_miny) n_miny = i_data.y_coord;
                        if (i_data.y_coord > r_maxy) n_maxy = i_data.y_coord;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_data.last_point) n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                n_range = (w_rx > w_ry) ? w_rx : w_ry;
                if (n_range == '0) n_range = CRD_W'(1);
                n_i = '0;
                n_state = (r_cnt == '0) ? S_LOAD : S_RDPT;
            end
            S_RDPT: n_state = S_DIVX;   // point read data lands
            S_DIVX: begin
                if (r_lvl == '0 && !div_done) begin
                    // lvl doubles as a started flag here
                    div_start = 1'b1;
                    div_num = {w_dx, {GRID_BITS{1'b0}}} - NUM_W'(w_dx);
                    n_lvl = LVL_W'(1);
                end else if (div_done) begin
                    n_gx = div_q;
                    div_start = 1'b1;
                    div_num = {w_dy, {GRID_BITS{1'b0}}} - NUM_W'(w_dy);
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_gy = div_q;
                    n_key = '0;
                    n_lvl = LVL_W'(GRID_BITS);
                    n_state = S_HILB;
                end
            end
            S_HILB: begin
                n_key = {r_key[KEY_W-3:0], w_quad};
                n_gx = {r_gx[GRID_BITS-2:0], 1'b0};
                n_gy = {r_gy[GRID_BITS-2:0], 1'b0};
                if (!w_by) begin
                    if (w_bx) begin
                        n_gx = {~r_gy[GRID_BITS-2:0], 1'b0};
                        n_gy = {~r_gx[GRID_BITS-2:0], 1'b0};
                    end else begin
                        n_gx = {r_gy[GRID_BITS-2:0], 1'b0};
                        n_gy = {r_gx[GRID_BITS-2:0], 1'b0};
                    end
                end
                n_lvl = r_lvl - 1'b1;
                if (r_lvl == LVL_W'(1)) n_state = S_WRKEY;
            end
            S_WRKEY: begin
                km_we = 1'b1;
                n_lvl = '0;
                n_i = r_i + 1'b1;
                if (w_final) begin
                    n_i = '0;
                    n_state = S_SORT_START;
                end else begin
                    n_state = S_RDPT;
                end
            end
            S_SORT_START: begin
                // start insertion of position i; its key read is issued here
                if (r_i == r_cnt) begin
                    n_i = '0;
                    n_gpos = '0;
                    n_gnum = '0;
                    n_state = S_OUT_ORD;
                end else begin
                    n_cur = r_i[IDX_W-1:0];
                    n_j = r_i;
                    n_state = S_SORT_KEY;
                end
            end
            S_SORT_KEY: begin
                n_curkey = r_krd;
                n_state = S_SORT_PROBE;
            end
            S_SORT_PROBE: begin
                // drop cur into slot j at the front, else fetch order[j-1]
                if (r_j == '0) begin
                    om_we = 1'b1;
                    n_i = r_i + 1'b1;
                    n_state = S_SORT_START;
                end else begin
                    om_ra = w_jm1;
                    n_state = S_SORT_ORD;
                end
            end
            S_SORT_ORD: begin
                // hold the order address, read the key of order[j-1]
                om_ra = w_jm1;
                km_ra = r_ord;
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                om_we = 1'b1;
                if (r_krd > r_curkey) begin
                    // shift order[j-1] up one slot and keep probing
                    om_wd = r_ord;
                    n_j = r_j - 1'b1;
                    n_state = S_SORT_PROBE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SORT_START;
                end
            end
            S_OUT_ORD: begin
                n_state = S_OUT_MEM;
            end
            S_OUT_MEM: begin
                pm_ra = r_ord;
                km_ra = r_ord;
                n_state = S_OUT_SEND;
            end
            S_OUT_SEND: begin
                // hold addresses so the beat stays stable while stalled
                pm_ra = r_ord;
                km_ra = r_ord;
                o_valid = 1'b1;
                if (i_ready) begin
                    n_i = r_i + 1'b1;
                    if (r_gpos == w_gs - 1'b1) begin
                        n_gpos = '0;
                        n_gnum = r_gnum + 1'b1;
                    end else begin
                        n_gpos = r_gpos + 1'b1;
                    end
                    if (w_final) begin
                        n_state = S_LOAD;
                        n_cnt = '0; n_drop = 1'b0;
                        n_minx = '1; n_miny = '1; n_maxx = '0; n_maxy = '0;
                    end else begin
                        n_state = S_OUT_ORD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_gsz <= GSZ_RESET;
            r_cnt <= '0; r_drop <= 1'b0;
            r_minx <= '1; r_miny <= '1; r_maxx <= '0; r_maxy <= '0;
            r_i <= '0; r_j <= '0; r_lvl <= '0;
            r_gpos <= '0; r_gnum <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_GSZ) r_gsz <= pwdata[GSZ_W-1:0];
            r_state <= n_state;
            r_cnt <= n_cnt; r_drop <= n_drop;
            r_minx <= n_minx; r_miny <= n_miny; r_maxx <= n_maxx; r_maxy <= n_maxy;
            r_i <= n_i; r_j <= n_j;
            r_lvl <= n_lvl; r_gpos <= n_gpos; r_gnum <= n_gnum;
        end
        r_range <= n_range; r_cur <= n_cur; r_curkey <= n_curkey;
        r_gx <= n_gx; r_gy <= n_gy; r_key <= n_key;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pm_we) r_pmem[pm_wa] <= {i_data.point_tag, i_data.y_coord, i_data.x_coord};
        r_prd <= r_pmem[pm_ra];
        if (km_we) r_kmem[km_wa] <= r_key;
        r_krd <= r_kmem[km_ra];
        if (om_we) r_omem[om_wa] <= om_wd;
        r_ord <= r_omem[om_ra];
    end

    assign o_data.out_tag      = r_prd[47:32];
    assign o_data.hilbert_key  = r_krd;
    assign o_data.group_number = r_gnum;
    assign o_data.group_end    = w_final || (r_gpos == w_gs - 1'b1);
    assign o_data.set_end      = w_final;
    assign o_data.overflowed   = r_drop;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS)) else $error("point count overrun");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready during output");
    a_set_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.set_end) |=> (r_cnt == '0))
        else $error("set not cleared");
endmodule

// ===== sv/hog_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used for the grid mapping.
// Depends on hog_pkg.
module hog_divider
    import hog_pkg::*;
#(
    parameter int NUM_W = 47,
    parameter int DEN_W = 16,
    parameter int Q_W   = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q, n_q;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W+1:0] w_trial;

    // load on start, else one shift-subtract step while busy
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = '0;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_q    = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            w_trial = {r_rem, r_num[NUM_W-1]} - {2'b00, r_den};
            n_num = {r_num[NUM_W-2:0], 1'b0};
            if (!w_trial[DEN_W+1]) begin
                n_rem = w_trial[DEN_W:0];
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q[Q_W-1:0];
endmodule

// ===== dv/hilbert_order_grouper_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hilbert_order_grouper_core: directed and random point
// sets are sorted along a Hilbert curve by a local predictor. Depends on hog_pkg and the core.
module hilbert_order_grouper_core_tb;
    import hog_pkg::*;

    localparam int CAP = 64;
    localparam int GBITS = 31;
    localparam longint LIMIT = 64'd6000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_beat    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_beat   o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    hilbert_order_grouper_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [15:0] set_x [CAP];
    logic [15:0] set_y [CAP];
    logic [15:0] set_tag [CAP];
    logic [61:0] set_key [CAP];
    int          set_cnt;
    logic [15:0] lo_x, hi_x, lo_y, hi_y;
    logic        dropped;
    logic [6:0]  grp_size;

    t_in_beat  pending_points [$];
    t_out_beat sorted_beats [$];
    int        errors;
    longint    cycles;

    task automatic clear_set();
        set_cnt = 0;
        lo_x = 16'hFFFF; lo_y = 16'hFFFF;
        hi_x = '0; hi_y = '0;
        dropped = 1'b0;
    endtask

    function automatic logic [61:0] hilbert_of(logic [30:0] gx, logic [30:0] gy);
        logic [30:0] x, y, t;
        logic [63:0] d;
        logic        rx, ry;
        x = gx; y = gy; d = '0;
        for (int lvl = GBITS - 1; lvl >= 0; lvl--) begin
            rx = x[lvl];
            ry = y[lvl];
            d += ({2'b0, 62'(64'd1 << (2 * lvl))}) * 64'({rx, rx ^ ry});
            if (!ry) begin
                if (rx) begin
                    x = ~x;
                    y = ~y;
                end
                t = x; x = y; y = t;
            end
        end
        return d[61:0];
    endfunction

    function automatic logic [30:0] to_grid(logic [15:0] v, logic [15:0] lo,
                                            logic [16:0] rng);
        logic [63:0] num;
        num = 64'(16'(v - lo)) * 64'h7FFF_FFFF;
        return 31'(num / 64'(rng));
    endfunction

    // absorb one point; on the last one queue the sorted set
    task automatic predict_point(t_in_beat p);
        logic [16:0] rng, rx, ry;
        int          ord [CAP];
        int          j, cur, gs;
        t_out_beat   b;
        if (set_cnt < CAP) begin
            set_x[set_cnt] = p.x_coord;
            set_y[set_cnt] = p.y_coord;
            set_tag[set_cnt] = p.point_tag;
            set_cnt++;
            if (p.x_coord < lo_x) lo_x = p.x_coord;
            if (p.x_coord > hi_x) hi_x = p.x_coord;
            if (p.y_coord < lo_y) lo_y = p.y_coord;
            if (p.y_coord > hi_y) hi_y = p.y_coord;
        end else begin
            dropped = 1'b1;
        end
        if (!p.last_point) return;
        rx = (hi_x >= lo_x) ? 17'(hi_x - lo_x) : '0;
        ry = (hi_y >= lo_y) ? 17'(hi_y - lo_y) : '0;
        rng = (rx > ry) ? rx : ry;
        if (rng == '0) rng = 17'd1;
        for (int i = 0; i < set_cnt; i++)
            set_key[i] = hilbert_of(to_grid(set_x[i], lo_x, rng),
                                    to_grid(set_y[i], lo_y, rng));
        // stable insertion sort
        for (int i = 0; i < set_cnt; i++) begin
            j = i; cur = i;
            while (j > 0 && set_key[ord[j-1]] > set_key[cur]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = cur;
        end
        gs = (grp_size == 0) ? 1 : grp_size;
        for (int i = 0; i < set_cnt; i++) begin
            b.out_tag = set_tag[ord[i]];
            b.hilbert_key = set_key[ord[i]];
            b.group_number = 6'(i / gs);
            b.set_end = (i + 1 == set_cnt);
            b.group_end = b.set_end || (i % gs == gs - 1);
            b.overflowed = dropped;
            sorted_beats = {sorted_beats, b};
        end
        clear_set();
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: hold valid and payload until the beat is taken
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_point(i_data);
                if (drv_gap == 0 && pending_points.size() > 0 && gap_len() == 0)
                    i_data <= pending_points.pop_front();
                else begin
                    i_valid <= 1'b0;
                    drv_gap <= gap_len();
                end
            end else if (!i_valid) begin
                if (drv_gap > 0) drv_gap <= drv_gap - 1;
                else if (pending_points.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data <= pending_points.pop_front();
                end
            end
        end
    end

    // monitor: random back-pressure, compare each beat with the oldest expectation
    int mon_gap = 0;
    bit mon_stall_mode = 0;
    always @(posedge i_clk) begin
        t_out_beat w;
        cycles++;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (sorted_beats.size() == 0) begin
                    report("unexpected beat", 64'(o_data.out_tag), '0);
                end else begin
                    w = sorted_beats.pop_front();
                    if (o_data.out_tag !== w.out_tag)
                        report("out_tag", 64'(o_data.out_tag), 64'(w.out_tag));
                    if (o_data.hilbert_key !== w.hilbert_key)
                        report("hilbert_key", 64'(o_data.hilbert_key), 64'(w.hilbert_key));
                    if (o_data.group_number !== w.group_number)
                        report("group_number", 64'(o_data.group_number),
                               64'(w.group_number));
                    if (o_data.group_end !== w.group_end)
                        report("group_end", 64'(o_data.group_end), 64'(w.group_end));
                    if (o_data.set_end !== w.set_end)
                        report("set_end", 64'(o_data.set_end), 64'(w.set_end));
                    if (o_data.overflowed !== w.overflowed)
                        report("overflowed", 64'(o_data.overflowed), 64'(w.overflowed));
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                i_ready <= 1'b0;
            end else if (mon_stall_mode && $urandom_range(0, 3) == 0) begin
                mon_gap <= gap_len();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic apb_write(logic [6:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_GSZ; pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        grp_size = val;
    endtask

    task automatic add_point(logic [15:0] x, logic [15:0] y, logic last);
        t_in_beat p;
        p.x_coord = x; p.y_coord = y;
        p.point_tag = 16'($urandom);
        p.last_point = last;
        pending_points = {pending_points, p};
    endtask

    // random set of n points; mostly clustered, some full-range
    task automatic add_set(int n);
        logic [15:0] bx, by, spread, xv, yv;
        bx = 16'($urandom); by = 16'($urandom);
        spread = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 300));
        for (int i = 0; i < n; i++) begin
            xv = 16'(bx + 16'($urandom) % (spread + 17'd1));
            yv = 16'(by + 16'($urandom) % (spread + 17'd1));
            if ($urandom_range(0, 3) == 0) xv = 16'($urandom);
            if ($urandom_range(0, 3) == 0) yv = 16'($urandom);
            add_point(xv, yv, i == n - 1);
        end
    endtask

    // wait for the queues to drain, then let the block settle
    task automatic drain();
        wait (pending_points.size() == 0 && !i_valid && sorted_beats.size() == 0);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        int left;
        errors = 0; cycles = 0;
        grp_size = GSZ_RESET;
        clear_set();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, identical points, single point
        add_point(16'h0000, 16'h0000, 1'b0);
        add_point(16'hFFFF, 16'hFFFF, 1'b0);
        add_point(16'h0000, 16'hFFFF, 1'b0);
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h8000, 16'h7FFF, 1'b1);
        add_point(16'h1234, 16'h4321, 1'b0);
        add_point(16'h1234, 16'h4321, 1'b0);
        add_point(16'h1234, 16'h4321, 1'b1);
        add_point(16'hAAAA, 16'h5555, 1'b1);
        drain();

        // group size zero, then one, with a set split across groups
        apb_write(7'd0);
        add_set(7);
        drain();
        apb_write(7'd1);
        mon_stall_mode = 1;
        add_set(5);
        drain();

        // capacity exceeded: drops, including a dropped last point
        apb_write(7'd64);
        add_set(CAP + 3);
        drain();
        apb_write(7'd127);
        add_set(12);
        drain();

        // random phase
        left = 180;
        while (left > 0) begin
            apb_write(7'($urandom_range(1, 9)));
            for (int k = 0; k < 4 && left > 0; k++) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                                : $urandom_range(1, 12);
                add_set(n);
                left -= n;
            end
            mon_stall_mode = $urandom_range(0, 1);
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0 && sorted_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hog_pkg.sv
sv/hog_divider.sv
sv/hilbert_order_grouper_core.sv
dv/hilbert_order_grouper_core_tb.sv
